/* rtl/core/quad_attitude_pd_mixer_macros.svh */
// Assertion helpers for the attitude mixer; clocked on clk_i, off during reset.
`ifndef QUAD_ATTITUDE_PD_MIXER_MACROS_SVH
`define QUAD_ATTITUDE_PD_MIXER_MACROS_SVH

// same-cycle implication
`define QAPM_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("qapm: same-cycle check failed");

// next-cycle implication
`define QAPM_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("qapm: next-cycle check failed");

`endif

/* rtl/core/qapm_pkg.sv */
`timescale 1ns / 1ps
package qapm_pkg;

  localparam int DATA_W    = 24;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 12;
  localparam int GAINS_W   = 3 * GAIN_W;
  localparam int INV_DT_W  = 10;
  localparam int BASE_W    = 23;

  localparam int DIFF_W  = DATA_W + 1;          // difference of two samples
  localparam int ANG_W   = DATA_W + 2;          // angle error after yaw wrap
  localparam int ERR_W   = DATA_W + INV_DT_W + 2; // rate error, multiplier operand
  localparam int PROD_W  = ERR_W + GAIN_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int DELTA_W = ACC_W - GAIN_FRAC;
  localparam int MOTOR_W = DELTA_W + 3;

  localparam int APB_DW = 64;
  localparam int APB_AW = 6;

  localparam logic [2:0] REG_PITCH = 3'd0;
  localparam logic [2:0] REG_ROLL  = 3'd1;
  localparam logic [2:0] REG_YAW   = 3'd2;
  localparam logic [2:0] REG_INVDT = 3'd3;
  localparam logic [2:0] REG_BASE  = 3'd4;

  localparam logic [INV_DT_W-1:0] INV_DT_RST = INV_DT_W'(100);

  localparam logic [1:0] AX_PITCH = 2'd0;
  localparam logic [1:0] AX_ROLL  = 2'd1;
  localparam logic [1:0] AX_YAW   = 2'd2;

  localparam logic [1:0] SLOT_P  = 2'd0;
  localparam logic [1:0] SLOT_D  = 2'd1;
  localparam logic [1:0] SLOT_DD = 2'd2;

  localparam logic signed [ANG_W-1:0] PI_Q16     = ANG_W'(205887);
  localparam logic signed [ANG_W-1:0] NEG_PI_Q16 = -ANG_W'(205887);
  localparam logic signed [ANG_W-1:0] TWO_PI_Q16 = ANG_W'(411775);

  localparam logic signed [MOTOR_W-1:0] OUT_MAX = MOTOR_W'((2 ** (DATA_W - 1)) - 1);
  localparam logic signed [MOTOR_W-1:0] OUT_MIN = -MOTOR_W'(2 ** (DATA_W - 1));

  // per motor, bit a set: the delta of axis a is subtracted
  // order: front left, front right, rear right, rear left
  localparam logic [2:0] MIX_NEG [4] = '{3'b000, 3'b110, 3'b011, 3'b101};

  typedef struct packed {
    logic [GAINS_W-1:0]  pitch_gains;
    logic [GAINS_W-1:0]  roll_gains;
    logic [GAINS_W-1:0]  yaw_gains;
    logic [INV_DT_W-1:0] inv_dt;
    logic [BASE_W-1:0]   thrust_bias;
  } cfg_t;

  function automatic logic signed [GAIN_W-1:0] gain_at(logic [GAINS_W-1:0] gains,
                                                       logic [1:0] slot);
    logic signed [GAIN_W-1:0] g;
    unique case (slot)
      SLOT_P:  g = $signed(gains[GAIN_W-1:0]);
      SLOT_D:  g = $signed(gains[2*GAIN_W-1:GAIN_W]);
      default: g = $signed(gains[3*GAIN_W-1:2*GAIN_W]);
    endcase
    return g;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_out(logic signed [MOTOR_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    priority if (v > OUT_MAX) begin
      r = OUT_MAX[DATA_W-1:0];
    end else if (v < OUT_MIN) begin
      r = OUT_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/qapm_regs.sv */
`timescale 1ns / 1ps
module qapm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qapm_pkg::APB_AW-1:0]   paddr,
  input  logic [qapm_pkg::APB_DW-1:0]   pwdata,
  output logic [qapm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output qapm_pkg::cfg_t                cfg_o
);

  qapm_pkg::cfg_t cfg_q;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[qapm_pkg::APB_AW-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pitch_gains <= '0;
      cfg_q.roll_gains  <= '0;
      cfg_q.yaw_gains   <= '0;
      cfg_q.inv_dt      <= qapm_pkg::INV_DT_RST;
      cfg_q.thrust_bias <= '0;
    end else if (wr_en) begin
      unique case (idx)
        qapm_pkg::REG_PITCH: cfg_q.pitch_gains <= pwdata[qapm_pkg::GAINS_W-1:0];
        qapm_pkg::REG_ROLL:  cfg_q.roll_gains  <= pwdata[qapm_pkg::GAINS_W-1:0];
        qapm_pkg::REG_YAW:   cfg_q.yaw_gains   <= pwdata[qapm_pkg::GAINS_W-1:0];
        qapm_pkg::REG_INVDT: cfg_q.inv_dt      <= pwdata[qapm_pkg::INV_DT_W-1:0];
        qapm_pkg::REG_BASE:  cfg_q.thrust_bias <= pwdata[qapm_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      qapm_pkg::REG_PITCH: prdata = qapm_pkg::APB_DW'(cfg_q.pitch_gains);
      qapm_pkg::REG_ROLL:  prdata = qapm_pkg::APB_DW'(cfg_q.roll_gains);
      qapm_pkg::REG_YAW:   prdata = qapm_pkg::APB_DW'(cfg_q.yaw_gains);
      qapm_pkg::REG_INVDT: prdata = qapm_pkg::APB_DW'(cfg_q.inv_dt);
      qapm_pkg::REG_BASE:  prdata = qapm_pkg::APB_DW'(cfg_q.thrust_bias);
      default:             prdata = '0;
    endcase
  end

endmodule

/* rtl/core/qapm_mul.sv */
`timescale 1ns / 1ps
module qapm_mul (
  input  logic                                 clk_i,
  input  logic signed [qapm_pkg::ERR_W-1:0]    a_i,
  input  logic signed [qapm_pkg::GAIN_W-1:0]   b_i,
  output logic signed [qapm_pkg::PROD_W-1:0]   p_o
);

  logic signed [qapm_pkg::PROD_W-1:0] p_q;
  logic signed [qapm_pkg::PROD_W-1:0] p_d;

  assign p_d = qapm_pkg::PROD_W'(a_i) * qapm_pkg::PROD_W'(b_i);
  assign p_o = p_q;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

endmodule

/* rtl/core/qapm_core.sv */
`timescale 1ns / 1ps
module qapm_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  qapm_pkg::cfg_t                        cfg_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [qapm_pkg::DATA_W-1:0]    des_i [3],
  input  logic signed [qapm_pkg::DATA_W-1:0]    est_i [3],
  input  logic signed [qapm_pkg::DATA_W-1:0]    gyro_i [3],
  input  logic signed [qapm_pkg::DATA_W-1:0]    acc_i [3],
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [qapm_pkg::DATA_W-1:0]    motor_o [4],
  output logic signed [qapm_pkg::ERR_W-1:0]     mul_a_o,
  output logic signed [qapm_pkg::GAIN_W-1:0]    mul_b_o,
  input  logic signed [qapm_pkg::PROD_W-1:0]    mul_p_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_RATE, S_P, S_D, S_DD, S_SUM, S_MIX, S_OUT
  } state_e;

  state_e state_q;
  logic [1:0] ax_q;
  logic out_valid_q;

  logic signed [qapm_pkg::DATA_W-1:0]  des_q [3];
  logic signed [qapm_pkg::DATA_W-1:0]  est_q [3];
  logic signed [qapm_pkg::DATA_W-1:0]  gyro_q [3];
  logic signed [qapm_pkg::DATA_W-1:0]  acc_q [3];
  logic signed [qapm_pkg::DATA_W-1:0]  prev_q [3];
  logic signed [qapm_pkg::ANG_W-1:0]   ang_err_q;
  logic signed [qapm_pkg::ERR_W-1:0]   rate_err_q;
  logic signed [qapm_pkg::ACC_W-1:0]   sum_q;
  logic signed [qapm_pkg::MOTOR_W-1:0] mot_q [4];
  logic signed [qapm_pkg::DATA_W-1:0]  out_q [4];

  logic [qapm_pkg::GAINS_W-1:0]        gains;
  logic signed [qapm_pkg::DIFF_W-1:0]  des_diff;
  logic signed [qapm_pkg::DIFF_W-1:0]  ang_diff;
  logic signed [qapm_pkg::ANG_W-1:0]   ang_raw;
  logic signed [qapm_pkg::ANG_W-1:0]   ang_err_d;
  logic signed [qapm_pkg::DELTA_W-1:0] delta;
  logic signed [qapm_pkg::MOTOR_W-1:0] delta_m;
  logic                                out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign motor_o     = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (ax_q)
      qapm_pkg::AX_PITCH: gains = cfg_i.pitch_gains;
      qapm_pkg::AX_ROLL:  gains = cfg_i.roll_gains;
      default:            gains = cfg_i.yaw_gains;
    endcase
  end

  assign des_diff = qapm_pkg::DIFF_W'(des_q[ax_q]) - qapm_pkg::DIFF_W'(prev_q[ax_q]);
  assign ang_diff = qapm_pkg::DIFF_W'(des_q[ax_q]) - qapm_pkg::DIFF_W'(est_q[ax_q]);
  assign ang_raw  = qapm_pkg::ANG_W'(ang_diff);

  // yaw error shifted once by 2*pi toward [-pi, pi)
  always_comb begin
    ang_err_d = ang_raw;
    if (ax_q == qapm_pkg::AX_YAW) begin
      priority if (ang_raw >= qapm_pkg::PI_Q16) begin
        ang_err_d = ang_raw - qapm_pkg::TWO_PI_Q16;
      end else if (ang_raw < qapm_pkg::NEG_PI_Q16) begin
        ang_err_d = ang_raw + qapm_pkg::TWO_PI_Q16;
      end else begin
        ang_err_d = ang_raw;
      end
    end
  end

  // floor shift of the gain-scaled sum back to Q.16
  assign delta   = qapm_pkg::DELTA_W'(sum_q >>> qapm_pkg::GAIN_FRAC);
  assign delta_m = qapm_pkg::MOTOR_W'(delta);

  // operand select for the shared multiplier
  always_comb begin
    mul_a_o = '0;
    mul_b_o = '0;
    unique case (state_q)
      S_RATE: begin
        mul_a_o = qapm_pkg::ERR_W'(des_diff);
        mul_b_o = $signed(qapm_pkg::GAIN_W'(cfg_i.inv_dt));
      end
      S_P: begin
        mul_a_o = qapm_pkg::ERR_W'(ang_err_q);
        mul_b_o = qapm_pkg::gain_at(gains, qapm_pkg::SLOT_P);
      end
      S_D: begin
        mul_a_o = rate_err_q;
        mul_b_o = qapm_pkg::gain_at(gains, qapm_pkg::SLOT_D);
      end
      S_DD: begin
        mul_a_o = -qapm_pkg::ERR_W'(acc_q[ax_q]);
        mul_b_o = qapm_pkg::gain_at(gains, qapm_pkg::SLOT_DD);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ax_q        <= qapm_pkg::AX_PITCH;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev_q[i] <= '0;
      end
    end else begin
      // in S_OUT the result register is reloaded below instead
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            des_q   <= des_i;
            est_q   <= est_i;
            gyro_q  <= gyro_i;
            acc_q   <= acc_i;
            ax_q    <= qapm_pkg::AX_PITCH;
            for (int m = 0; m < 4; m++) begin
              mot_q[m] <= qapm_pkg::MOTOR_W'(cfg_i.thrust_bias);
            end
            state_q <= S_RATE;
          end
        end
        S_RATE: begin
          ang_err_q <= ang_err_d;
          state_q   <= S_P;
        end
        S_P: begin
          // product holds the desired rate, which fits the operand width
          rate_err_q <= qapm_pkg::ERR_W'(mul_p_i) - qapm_pkg::ERR_W'(gyro_q[ax_q]);
          state_q    <= S_D;
        end
        S_D: begin
          sum_q   <= qapm_pkg::ACC_W'(mul_p_i);
          state_q <= S_DD;
        end
        S_DD: begin
          sum_q   <= sum_q + qapm_pkg::ACC_W'(mul_p_i);
          state_q <= S_SUM;
        end
        S_SUM: begin
          sum_q   <= sum_q + qapm_pkg::ACC_W'(mul_p_i);
          state_q <= S_MIX;
        end
        S_MIX: begin
          for (int m = 0; m < 4; m++) begin
            if (qapm_pkg::MIX_NEG[m][ax_q]) begin
              mot_q[m] <= mot_q[m] - delta_m;
            end else begin
              mot_q[m] <= mot_q[m] + delta_m;
            end
          end
          if (ax_q == qapm_pkg::AX_YAW) begin
            state_q <= S_OUT;
          end else begin
            ax_q    <= ax_q + 2'd1;
            state_q <= S_RATE;
          end
        end
        S_OUT: begin
          // holds here while the previous result still waits
          if (out_free) begin
            for (int m = 0; m < 4; m++) begin
              out_q[m] <= qapm_pkg::sat_out(mot_q[m]);
            end
            prev_q      <= des_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/quad_attitude_pd_mixer.sv */
`timescale 1ns / 1ps
// Attitude P-D-DD controller with X-frame motor mixer. One beat of desired and
// estimated angles, gyro rates and angular accelerations gives one beat of four
// saturated motor thrusts (signed Q7.16). A single 36x16 multiplier is shared
// by all products under a sequencer that runs through each axis in turn
// (desired rate, then the P, D and DD products, accumulate, mix), and the block
// takes a new input beat only once the sequencer is back in idle. While a
// result waits on the output, the next item is already worked on; it is held
// at the end only if the earlier result is still not taken.
// Gains, inv_dt and base thrust sit on the APB port at byte addresses 8*i and
// should be written while the block is idle.
`include "quad_attitude_pd_mixer_macros.svh"
module quad_attitude_pd_mixer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [qapm_pkg::APB_AW-1:0]          paddr,
  input  logic [qapm_pkg::APB_DW-1:0]          pwdata,
  output logic [qapm_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [qapm_pkg::DATA_W-1:0]   des_pitch_i,
  input  logic signed [qapm_pkg::DATA_W-1:0]   des_roll_i,
  input  logic signed [qapm_pkg::DATA_W-1:0]   des_yaw_i,
  input  logic signed [qapm_pkg::DATA_W-1:0]   est_pitch_i,
  input  logic signed [qapm_pkg::DATA_W-1:0]   est_roll_i,
  input  logic signed [qapm_pkg::DATA_W-1:0]   est_yaw_i,
  input  logic signed [qapm_pkg::DATA_W-1:0]   gyro_x_i,
  input  logic signed [qapm_pkg::DATA_W-1:0]   gyro_y_i,
  input  logic signed [qapm_pkg::DATA_W-1:0]   gyro_z_i,
  input  logic signed [qapm_pkg::DATA_W-1:0]   acc_pitch_i,
  input  logic signed [qapm_pkg::DATA_W-1:0]   acc_roll_i,
  input  logic signed [qapm_pkg::DATA_W-1:0]   acc_yaw_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [qapm_pkg::DATA_W-1:0]   motor_front_left_o,
  output logic signed [qapm_pkg::DATA_W-1:0]   motor_front_right_o,
  output logic signed [qapm_pkg::DATA_W-1:0]   motor_rear_right_o,
  output logic signed [qapm_pkg::DATA_W-1:0]   motor_rear_left_o
);

  qapm_pkg::cfg_t cfg;

  logic signed [qapm_pkg::DATA_W-1:0] des [3];
  logic signed [qapm_pkg::DATA_W-1:0] est [3];
  logic signed [qapm_pkg::DATA_W-1:0] gyro [3];
  logic signed [qapm_pkg::DATA_W-1:0] acc [3];
  logic signed [qapm_pkg::DATA_W-1:0] motor [4];

  logic signed [qapm_pkg::ERR_W-1:0]  mul_a;
  logic signed [qapm_pkg::GAIN_W-1:0] mul_b;
  logic signed [qapm_pkg::PROD_W-1:0] mul_p;

  assign des  = '{des_pitch_i, des_roll_i, des_yaw_i};
  assign est  = '{est_pitch_i, est_roll_i, est_yaw_i};
  assign gyro = '{gyro_x_i, gyro_y_i, gyro_z_i};
  assign acc  = '{acc_pitch_i, acc_roll_i, acc_yaw_i};

  assign motor_front_left_o  = motor[0];
  assign motor_front_right_o = motor[1];
  assign motor_rear_right_o  = motor[2];
  assign motor_rear_left_o   = motor[3];

  qapm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  qapm_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  qapm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .des_i       (des),
    .est_i       (est),
    .gyro_i      (gyro),
    .acc_i       (acc),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .motor_o     (motor),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .mul_p_i     (mul_p)
  );

  // an accepted beat keeps the sequencer busy
  `QAPM_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  // a new result only comes out of a running computation
  `QAPM_ASSERT_NOW(a_result_from_work, $rose(out_valid_o), $past(!in_ready_o))
  // a result is dropped only when taken
  `QAPM_ASSERT_NOW(a_result_held, $fell(out_valid_o), $past(out_ready_i))

endmodule
